>>> hdl/rrts_pkg.sv
// Shared types and codes for the round-robin thread scheduler.
// No dependencies; used by rrts_queue, the scheduler top and the testbench.
`timescale 1ns / 1ps

package rrts_pkg;

    // Event codes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_EXIT   = 3'd1;
    localparam logic [2:0] OP_BLOCK  = 3'd2;
    localparam logic [2:0] OP_WAKE   = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    // Widest thread id the block supports internally
    localparam int MAX_ID_BITS = 16;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tid;
    } evt_t;

    typedef struct packed {
        logic [7:0] running_id;
        logic       cpu_idle;
        logic       queue_overflow;
    } res_t;

    // Queue control from the scheduler
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    // Queue status back to the scheduler
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

>>> hdl/rrts_cell.sv
// One entry of the ready queue: holds a thread id, takes its neighbor's id on a shift.
// Depends on nothing.
`timescale 1ns / 1ps

module rrts_cell #(
    parameter int ID_BITS = 8
) (
    input  logic               clk,
    input  logic               shift,
    input  logic               load,
    input  logic [ID_BITS-1:0] load_id,
    input  logic [ID_BITS-1:0] next_id,
    output logic [ID_BITS-1:0] id
);

    logic [ID_BITS-1:0] id_reg;

    // Load wins over shift: a pop and push in the same cycle lands the new id behind the shift
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg <= load_id;
        end
        else if (shift)
        begin
            id_reg <= next_id;
        end
    end

    assign id = id_reg;

endmodule

>>> hdl/rrts_queue.sv
// Ready queue as a row of shifting cells; cell 0 is the head.
// Depends on rrts_pkg and rrts_cell.
`timescale 1ns / 1ps

module rrts_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrts_pkg::queue_ctrl_t ctrl,
    input  logic [ID_BITS-1:0]   push_id,
    output logic [ID_BITS-1:0]   head_id,
    output rrts_pkg::queue_stat_t stat
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      wpos_wide;
    logic [IW-1:0]      wpos;
    logic [ID_BITS-1:0] cell_id [QUEUE_DEPTH];

    // Write slot: tail after any shift of this cycle
    assign wpos_wide = ctrl.pop ? (count_reg - CW'(1)) : count_reg;
    assign wpos      = wpos_wide[IW-1:0];

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Row of cells, each handing its id toward the head on a pop
    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic [ID_BITS-1:0] nbr_id;
            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign nbr_id = '0;
            end
            else
            begin : g_mid
                assign nbr_id = cell_id[i+1];
            end

            rrts_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk     (clk),
                .shift   (ctrl.pop),
                .load    (ctrl.push && (wpos == IW'(i))),
                .load_id (push_id),
                .next_id (nbr_id),
                .id      (cell_id[i])
            );
        end
    endgenerate

    assign head_id    = cell_id[0];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(QUEUE_DEPTH));

endmodule

>>> hdl/round_robin_thread_scheduler_top.sv
// Round-robin time-slice scheduler: event decode, running thread, slice counter, result register.
// The result is registered on the event transfer and shows in the next cycle; throughput one event per cycle,
// set by the single result register (the event side stalls only while a result waits under res_stall).
// Queue push and pop are one shift of the cell row, so every event updates queue and state at its transfer.
// Reset (rst_n, async low): CPU idle, queue empty, time slice 1; queue cells are not cleared.
// Depends on rrts_pkg and rrts_queue.
`timescale 1ns / 1ps

module round_robin_thread_scheduler_top #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           evt_valid,
    output logic           evt_stall,
    input  rrts_pkg::evt_t evt_data,
    output logic           res_valid,
    input  logic           res_stall,
    output rrts_pkg::res_t res_data,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data
);

    localparam int WB = rrts_pkg::MAX_ID_BITS;

    logic [15:0]           time_slice_reg;
    logic [ID_BITS-1:0]    run_id_reg;
    logic [ID_BITS-1:0]    run_id_next;
    logic                  run_valid_reg;
    logic                  run_valid_next;
    logic [15:0]           ticks_reg;
    logic [15:0]           ticks_next;
    logic [15:0]           ticks_inc;
    logic [15:0]           limit;
    logic                  res_valid_reg;
    rrts_pkg::res_t        res_reg;
    rrts_pkg::res_t        res_next;
    logic                  accept;
    logic                  ovf;
    logic [WB-1:0]         in_wide;
    logic [ID_BITS-1:0]    in_id;
    logic [WB-1:0]         run_wide;
    logic [ID_BITS-1:0]    push_id;
    logic [ID_BITS-1:0]    head_id;
    rrts_pkg::queue_ctrl_t q_ctrl;
    rrts_pkg::queue_stat_t q_stat;

    assign evt_stall = res_valid_reg && res_stall;
    assign accept    = evt_valid && !evt_stall;

    // Mask or widen the incoming id to the internal width
    assign in_wide = WB'(evt_data.tid);
    assign in_id   = in_wide[ID_BITS-1:0];

    assign ticks_inc = ticks_reg + 16'd1;
    assign limit     = (time_slice_reg == 16'd0) ? 16'd1 : time_slice_reg;

    // Event decode and next scheduler state
    always_comb
    begin
        run_id_next    = run_id_reg;
        run_valid_next = run_valid_reg;
        ticks_next     = ticks_reg;
        q_ctrl         = '0;
        push_id        = in_id;
        ovf            = 1'b0;
        unique case (evt_data.op)
            rrts_pkg::OP_CREATE, rrts_pkg::OP_WAKE:
            begin
                if (!run_valid_reg)
                begin
                    run_id_next    = in_id;
                    run_valid_next = 1'b1;
                    ticks_next     = '0;
                end
                else if (q_stat.full)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    q_ctrl.push = 1'b1;
                end
            end
            rrts_pkg::OP_EXIT, rrts_pkg::OP_BLOCK:
            begin
                ticks_next = '0;
                if (!q_stat.empty)
                begin
                    run_id_next    = head_id;
                    run_valid_next = 1'b1;
                    q_ctrl.pop     = 1'b1;
                end
                else
                begin
                    run_id_next    = '0;
                    run_valid_next = 1'b0;
                end
            end
            rrts_pkg::OP_TICK:
            begin
                if (run_valid_reg)
                begin
                    if (ticks_inc >= limit)
                    begin
                        // Slice used up: rotate with the head
                        ticks_next = '0;
                        if (!q_stat.empty)
                        begin
                            run_id_next = head_id;
                            q_ctrl.pop  = 1'b1;
                            q_ctrl.push = 1'b1;
                            push_id     = run_id_reg;
                        end
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (!accept)
        begin
            q_ctrl = '0;
        end
    end

    // Result for this event
    assign run_wide = WB'(run_id_next);
    always_comb
    begin
        res_next.running_id     = run_valid_next ? run_wide[7:0] : 8'd0;
        res_next.cpu_idle       = !run_valid_next;
        res_next.queue_overflow = ovf;
    end

    rrts_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (q_ctrl),
        .push_id (push_id),
        .head_id (head_id),
        .stat    (q_stat)
    );

    // Scheduler state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_slice_reg <= 16'd1;
            run_id_reg     <= '0;
            run_valid_reg  <= 1'b0;
            ticks_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                time_slice_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                run_id_reg    <= run_id_next;
                run_valid_reg <= run_valid_next;
                ticks_reg     <= ticks_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

>>> test/tb_round_robin_thread_scheduler_top.sv
// Self-checking testbench for round_robin_thread_scheduler_top: directed event table, then
// random event streams under several time slices, idling patterns and one long result hold-off.
// Depends on rrts_pkg and the scheduler RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler_top;

    localparam int QUEUE_DEPTH    = 64;
    localparam int ID_BITS        = 8;
    localparam int RESULT_LATENCY = 1;
    localparam int PHASE_EVENTS   = 275;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // Event codes the block decodes as no-ops
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    typedef enum int {MOOD_FILL, MOOD_DRAIN, MOOD_MIXED} mood_t;

    // One row of the directed table; want is checked only when typed is set
    typedef struct {
        rrts_pkg::evt_t evt;
        bit             typed;
        rrts_pkg::res_t want;
    } event_row_t;

    typedef struct {
        bit             typed;
        rrts_pkg::res_t want;
    } status_note_t;

    typedef struct {
        rrts_pkg::res_t model;
        bit             typed;
        rrts_pkg::res_t want;
    } status_expect_t;

    logic           clk;
    logic           rst_n       = 1'b0;
    logic           evt_valid   = 1'b0;
    logic           evt_stall;
    rrts_pkg::evt_t evt_data    = '0;
    logic           res_valid;
    logic           res_stall   = 1'b0;
    rrts_pkg::res_t res_data;
    logic           cfg_wr_en   = 1'b0;
    logic [15:0]    cfg_wr_data = '0;

    // Scheduler model state
    logic [7:0]  ready_fifo[$];
    logic [7:0]  cpu_thread = '0;
    logic        cpu_busy   = 1'b0;
    logic [15:0] ticks_used = '0;
    logic [15:0] slice_len  = 16'd1;

    status_note_t   pending_notes_q[$];
    status_expect_t expected_status_q[$];
    event_row_t     directed_rows_q[$];

    int sched_errors   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_req       = 0;
    int quiet_cycles   = 0;

    logic [15:0] phase_slices[6] = '{16'd0, 16'd2, 16'hFFFF, 16'd7, 16'd1, 16'd3};

    round_robin_thread_scheduler_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (evt_valid),
        .evt_stall   (evt_stall),
        .evt_data    (evt_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Apply one event to the model and return the status it reports
    function automatic rrts_pkg::res_t schedule_event(input rrts_pkg::evt_t e);
        rrts_pkg::res_t r;
        logic [15:0]    limit;
        logic [7:0]     prev;
        r = '0;
        case (e.op)
            rrts_pkg::OP_CREATE, rrts_pkg::OP_WAKE:
            begin
                if (!cpu_busy)
                begin
                    cpu_thread = e.tid;
                    cpu_busy   = 1'b1;
                    ticks_used = '0;
                end
                else if (ready_fifo.size() >= QUEUE_DEPTH)
                begin
                    r.queue_overflow = 1'b1;
                end
                else
                begin
                    ready_fifo.push_back(e.tid);
                end
            end
            rrts_pkg::OP_EXIT, rrts_pkg::OP_BLOCK:
            begin
                if (ready_fifo.size() != 0)
                begin
                    cpu_thread = ready_fifo.pop_front();
                    cpu_busy   = 1'b1;
                end
                else
                begin
                    cpu_thread = '0;
                    cpu_busy   = 1'b0;
                end
                ticks_used = '0;
            end
            rrts_pkg::OP_TICK:
            begin
                if (cpu_busy)
                begin
                    limit      = (slice_len == 16'd0) ? 16'd1 : slice_len;
                    ticks_used = ticks_used + 16'd1;
                    if (ticks_used >= limit)
                    begin
                        // head leaves before the preempted thread joins, so no overflow
                        if (ready_fifo.size() != 0)
                        begin
                            prev       = cpu_thread;
                            cpu_thread = ready_fifo.pop_front();
                            ready_fifo.push_back(prev);
                        end
                        ticks_used = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.running_id = cpu_busy ? cpu_thread : 8'd0;
        r.cpu_idle   = !cpu_busy;
        return r;
    endfunction

    function automatic void compare_status(input rrts_pkg::res_t want,
                                           input rrts_pkg::res_t got);
        if (got.running_id !== want.running_id)
        begin
            $error("running_id: expected %0d, got %0d", want.running_id, got.running_id);
            sched_errors++;
        end
        if (got.cpu_idle !== want.cpu_idle)
        begin
            $error("cpu_idle: expected %0b, got %0b", want.cpu_idle, got.cpu_idle);
            sched_errors++;
        end
        if (got.queue_overflow !== want.queue_overflow)
        begin
            $error("queue_overflow: expected %0b, got %0b", want.queue_overflow,
                   got.queue_overflow);
            sched_errors++;
        end
    endfunction

    // Random event; the mood biases the queue toward filling or draining
    function automatic rrts_pkg::evt_t random_event(input mood_t mood);
        rrts_pkg::evt_t e;
        int             pick;
        int             join_lim;
        int             tick_lim;
        int             leave_lim;
        pick  = $urandom_range(99);
        e.tid = 8'($urandom_range(255));
        case (mood)
            MOOD_FILL:
            begin
                join_lim  = 60;
                tick_lim  = 85;
                leave_lim = 95;
            end
            MOOD_DRAIN:
            begin
                join_lim  = 20;
                tick_lim  = 35;
                leave_lim = 95;
            end
            default:
            begin
                join_lim  = 40;
                tick_lim  = 75;
                leave_lim = 97;
            end
        endcase
        if (pick < join_lim)
            e.op = $urandom_range(1) ? rrts_pkg::OP_CREATE : rrts_pkg::OP_WAKE;
        else if (pick < tick_lim)
            e.op = rrts_pkg::OP_TICK;
        else if (pick < leave_lim)
            e.op = $urandom_range(1) ? rrts_pkg::OP_EXIT : rrts_pkg::OP_BLOCK;
        else
            e.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        return e;
    endfunction

    function automatic void add_row(input logic [2:0] op, input logic [7:0] id, input bit typed,
                                    input logic [7:0] run_id, input logic idle);
        event_row_t row;
        row.evt.op                = op;
        row.evt.tid               = id;
        row.typed                 = typed;
        row.want.running_id       = run_id;
        row.want.cpu_idle         = idle;
        row.want.queue_overflow   = 1'b0;
        directed_rows_q.push_back(row);
    endfunction

    // Offer one event, with random idle cycles first, and wait for its transfer
    task automatic offer_event(input rrts_pkg::evt_t e, input bit typed,
                               input rrts_pkg::res_t want);
        status_note_t note;
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_valid <= 1'b0;
            @(posedge clk);
        end
        note.typed = typed;
        note.want  = want;
        pending_notes_q.push_back(note);
        evt_data  <= e;
        evt_valid <= 1'b1;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
    endtask

    task automatic run_random_phase(input int n_events);
        int             sent;
        int             seg_left;
        mood_t          mood;
        rrts_pkg::evt_t e;
        sent     = 0;
        seg_left = 0;
        mood     = MOOD_MIXED;
        while (sent < n_events)
        begin
            if (seg_left == 0)
            begin
                // fill twice as often as drain so the queue regularly saturates
                case ($urandom_range(3))
                    0, 1:    mood = MOOD_FILL;
                    2:       mood = MOOD_DRAIN;
                    default: mood = MOOD_MIXED;
                endcase
                seg_left = $urandom_range(20, 120);
            end
            seg_left--;
            e = random_event(mood);
            offer_event(e, 1'b0, '0);
            if (e.op <= rrts_pkg::OP_TICK)
                sent++;
        end
        evt_valid <= 1'b0;
    endtask

    // Let the next edge book the last transfer, then wait until every result has left
    task automatic wait_drained;
        @(posedge clk);
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    // Result side: random stall, or a long counted hold-off on request
    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Transfer monitor: predict on each event, check each result, watchdog
    always @(posedge clk)
    begin : monitor
        status_note_t   note;
        status_expect_t ex;
        bit             moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_wr_en)
                slice_len = cfg_wr_data;
            if (evt_valid && !evt_stall)
            begin
                note     = pending_notes_q.pop_front();
                ex.model = schedule_event(evt_data);
                ex.typed = note.typed;
                ex.want  = note.want;
                expected_status_q.push_back(ex);
                moved = 1'b1;
            end
            if (res_valid && !res_stall)
            begin
                if (expected_status_q.size() == 0)
                begin
                    $error("result transfer with no event pending: %p", res_data);
                    sched_errors++;
                end
                else
                begin
                    ex = expected_status_q.pop_front();
                    compare_status(ex.model, res_data);
                    if (ex.typed)
                        compare_status(ex.want, res_data);
                end
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("round_robin_thread_scheduler_top test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reset time slice of one
        send_idle_pct = 34;
        recv_idle_pct = 88;
        add_row(rrts_pkg::OP_TICK,   8'h00, 1, 8'h00, 1'b1);  // tick while idle
        add_row(rrts_pkg::OP_EXIT,   8'h00, 1, 8'h00, 1'b1);  // exit while idle, empty queue
        add_row(rrts_pkg::OP_BLOCK,  8'h3C, 1, 8'h00, 1'b1);
        add_row(OP_SPARE_HI,         8'hFF, 1, 8'h00, 1'b1);  // unused code
        add_row(rrts_pkg::OP_CREATE, 8'hFF, 1, 8'hFF, 1'b0);  // starts at once on idle CPU
        add_row(rrts_pkg::OP_CREATE, 8'h00, 1, 8'hFF, 1'b0);
        add_row(rrts_pkg::OP_WAKE,   8'hAA, 1, 8'hFF, 1'b0);
        add_row(OP_SPARE_MID,        8'h55, 1, 8'hFF, 1'b0);
        add_row(rrts_pkg::OP_TICK,   8'h00, 0, 8'h00, 1'b0);  // preempt
        add_row(rrts_pkg::OP_TICK,   8'h7E, 0, 8'h00, 1'b0);
        add_row(rrts_pkg::OP_CREATE, 8'h55, 0, 8'h00, 1'b0);
        add_row(rrts_pkg::OP_WAKE,   8'h55, 0, 8'h00, 1'b0);  // repeated id
        add_row(rrts_pkg::OP_EXIT,   8'h00, 0, 8'h00, 1'b0);
        add_row(rrts_pkg::OP_BLOCK,  8'h00, 0, 8'h00, 1'b0);
        add_row(OP_SPARE_LO,         8'h81, 0, 8'h00, 1'b0);
        add_row(rrts_pkg::OP_EXIT,   8'h00, 0, 8'h00, 1'b0);
        add_row(rrts_pkg::OP_EXIT,   8'h00, 0, 8'h00, 1'b0);  // last queued id runs
        add_row(rrts_pkg::OP_TICK,   8'h00, 0, 8'h00, 1'b0);  // preempt with empty queue
        add_row(rrts_pkg::OP_BLOCK,  8'h00, 1, 8'h00, 1'b1);
        add_row(rrts_pkg::OP_WAKE,   8'h01, 1, 8'h01, 1'b0);
        add_row(rrts_pkg::OP_EXIT,   8'h00, 1, 8'h00, 1'b1);
        foreach (directed_rows_q[i])
            offer_event(directed_rows_q[i].evt, directed_rows_q[i].typed,
                        directed_rows_q[i].want);
        evt_valid <= 1'b0;
        wait_drained();

        // Random phases, each under its own time slice and one of three idling patterns
        for (ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 88 : 0;
            recv_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 34 : 0;
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_slices[ph];
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            // long result hold-off so the block backs up into the event side
            if (ph == 4)
                hold_req++;
            run_random_phase(PHASE_EVENTS);
            wait_drained();
        end

        if (sched_errors == 0)
            $display("round_robin_thread_scheduler_top test passed");
        else
            $display("round_robin_thread_scheduler_top test failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/rrts_pkg.sv
hdl/rrts_cell.sv
hdl/rrts_queue.sv
hdl/round_robin_thread_scheduler_top.sv
test/tb_round_robin_thread_scheduler_top.sv
